### hdl/cfia_pkg.sv
// ----------------------------------------------------------------------------
// cfia_pkg
// Shared types and codes of the constant-fold integer alu.
// ----------------------------------------------------------------------------
package cfia_pkg;

  localparam int DATA_W        = 64;
  localparam int DEF_MAX_WIDTH = 64;

  // opcodes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_SHL  = 4'd3;
  localparam logic [3:0] OP_SDIV = 4'd4;
  localparam logic [3:0] OP_UDIV = 4'd5;
  localparam logic [3:0] OP_SMOD = 4'd6;
  localparam logic [3:0] OP_UMOD = 4'd7;
  localparam logic [3:0] OP_ASHR = 4'd8;
  localparam logic [3:0] OP_LSHR = 4'd9;
  localparam logic [3:0] OP_AND  = 4'd10;
  localparam logic [3:0] OP_OR   = 4'd11;
  localparam logic [3:0] OP_XOR  = 4'd12;
  localparam logic [3:0] OP_CMP  = 4'd13;

  // width codes
  localparam logic [2:0] WC_1  = 3'd0;
  localparam logic [2:0] WC_8  = 3'd1;
  localparam logic [2:0] WC_16 = 3'd2;
  localparam logic [2:0] WC_32 = 3'd3;
  localparam logic [2:0] WC_64 = 3'd4;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [2:0]        width_code;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic              no_signed_wrap;
    logic              no_unsigned_wrap;
    logic [4:0]        compare_mask;
  } cfia_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              valid_res;
  } cfia_out_t;

  // operand width in bits, 0 for an undefined code
  function automatic logic [6:0] width_bits(input logic [2:0] code);
    logic [6:0] w;
    case (code)
      WC_1:    w = 7'd1;
      WC_8:    w = 7'd8;
      WC_16:   w = 7'd16;
      WC_32:   w = 7'd32;
      WC_64:   w = 7'd64;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  // low-bit mask of a width code
  function automatic logic [DATA_W-1:0] width_mask(input logic [2:0] code);
    logic [DATA_W-1:0] m;
    case (code)
      WC_1:    m = 64'h0000_0000_0000_0001;
      WC_8:    m = 64'h0000_0000_0000_00ff;
      WC_16:   m = 64'h0000_0000_0000_ffff;
      WC_32:   m = 64'h0000_0000_ffff_ffff;
      WC_64:   m = 64'hffff_ffff_ffff_ffff;
      default: m = '0;
    endcase
    return m;
  endfunction

  // sign bit position of a width code, one-hot
  function automatic logic [DATA_W-1:0] width_top(input logic [2:0] code);
    logic [DATA_W-1:0] t;
    case (code)
      WC_1:    t = 64'h0000_0000_0000_0001;
      WC_8:    t = 64'h0000_0000_0000_0080;
      WC_16:   t = 64'h0000_0000_0000_8000;
      WC_32:   t = 64'h0000_0000_8000_0000;
      WC_64:   t = 64'h8000_0000_0000_0000;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### hdl/constant_fold_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// constant_fold_integer_alu_unit
// Pipelined integer alu with wrap flags for folding constant operations.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one operation (opcode, width code, two
//   operands, nsw/nuw flags, compare mask). out_valid/out_stall/out_data
//   return one result and its valid_res bit for every operation, in order.
//   A transfer takes place on a rising edge with valid high and stall low.
// Stages: every opcode passes through all of them, from input transfer to out_valid.
//   Four front stages (operand masking, add/shift/logic/compare and partial
//   products, flag checks, product sum), a divider load stage with the
//   product overflow check, a 64-stage restoring divider chain that retires
//   one quotient bit per stage, and the output register.
// Throughput: one operation per cycle while out_stall does not hold the pipeline; all stages move together.
// Stall: when out_valid is high and out_stall is high the whole pipeline
//   holds and in_stall is raised; no data is lost or repeated.
// Reset: rst_n low clears every stage valid bit; out_valid drops on the
//   next edge. Results of undefined operations carry valid_res = 0 and a
//   zero result.
// ----------------------------------------------------------------------------
module constant_fold_integer_alu_unit
  import cfia_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cfia_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cfia_out_t out_data
);

  localparam int DIV_STAGES = DATA_W;
  localparam logic [6:0] MAXW = 7'(MAX_WIDTH);

  typedef struct packed {
    logic [3:0]        op;
    logic [6:0]        w;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic              nsw;
    logic              nuw;
    logic [4:0]        cmask;
    logic              wok;
  } s1_t;

  typedef struct packed {
    logic [3:0]        op;
    logic              w_one;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] x;
    logic              sx;
    logic              nsw;
    logic              nuw;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] shl;
    logic [DATA_W-1:0] lshr;
    logic [DATA_W-1:0] ashr;
    logic [DATA_W-1:0] land;
    logic [DATA_W-1:0] lor;
    logic [DATA_W-1:0] lxor;
    logic              cmpb;
    logic              sh_ok;
    logic              yzero;
    logic              wok;
    logic [63:0]       pll;
    logic [63:0]       plh;
    logic [63:0]       phl;
    logic [63:0]       phh;
    logic [DATA_W-1:0] dvd;
    logic [DATA_W-1:0] dvs;
    logic              negq;
    logic              negr;
  } s2_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [DATA_W-1:0] m;
    logic              ok;
    logic              nuw;
    logic [DATA_W-1:0] pre;
    logic [63:0]       pll;
    logic [63:0]       phh;
    logic [64:0]       mid;
    logic [DATA_W-1:0] dvd;
    logic [DATA_W-1:0] dvs;
    logic              negq;
    logic              negr;
  } s3_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [DATA_W-1:0] m;
    logic              ok;
    logic              nuw;
    logic [DATA_W-1:0] pre;
    logic [127:0]      prod;
    logic [DATA_W-1:0] dvd;
    logic [DATA_W-1:0] dvs;
    logic              negq;
    logic              negr;
  } s4_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [DATA_W-1:0] m;
    logic              ok;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
    logic              negq;
    logic              negr;
  } dv_t;

  // one restoring division step: next quotient bit into num lsb
  function automatic dv_t div_step(input dv_t d);
    dv_t         n;
    logic [64:0] t;
    logic        ge;
    n  = d;
    t  = {d.rem, d.num[DATA_W-1]};
    ge = (t >= {1'b0, d.den});
    n.rem = ge ? 64'(t - {1'b0, d.den}) : t[DATA_W-1:0];
    n.num = {d.num[DATA_W-2:0], ge};
    return n;
  endfunction

  logic adv;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  logic      dv_v_r [0:DIV_STAGES];
  dv_t       dv_r   [0:DIV_STAGES];
  dv_t       dv0_nxt;
  logic      out_valid_r;
  cfia_out_t out_data_r, out_data_nxt;

  // whole pipeline moves unless the output holds a stalled transfer
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stage 1: decode width and mask operands
  always_comb begin
    s1_nxt.op    = in_data.opcode;
    s1_nxt.w     = width_bits(in_data.width_code);
    s1_nxt.m     = width_mask(in_data.width_code);
    s1_nxt.top   = width_top(in_data.width_code);
    s1_nxt.x     = in_data.operand_a & s1_nxt.m;
    s1_nxt.y     = in_data.operand_b & s1_nxt.m;
    s1_nxt.nsw   = in_data.no_signed_wrap;
    s1_nxt.nuw   = in_data.no_unsigned_wrap;
    s1_nxt.cmask = in_data.compare_mask;
    s1_nxt.wok   = (s1_nxt.w != 7'd0) && (s1_nxt.w <= MAXW);
  end

  // stage 2: add, subtract, shifts, logic, compare, partial products, magnitudes
  always_comb begin
    logic              sx, sy, ugt, ult, eq;
    logic [6:0]        sh;
    logic [DATA_W-1:0] ua, ub;
    sx = |(s1_r.x & s1_r.top);
    sy = |(s1_r.y & s1_r.top);
    sh = s1_r.y[6:0];
    ugt = s1_r.x > s1_r.y;
    ult = s1_r.x < s1_r.y;
    eq  = s1_r.x == s1_r.y;
    ua = sx ? ((64'd0 - s1_r.x) & s1_r.m) : s1_r.x;
    ub = sy ? ((64'd0 - s1_r.y) & s1_r.m) : s1_r.y;
    s2_nxt.op    = s1_r.op;
    s2_nxt.w_one = (s1_r.w == 7'd1);
    s2_nxt.m     = s1_r.m;
    s2_nxt.top   = s1_r.top;
    s2_nxt.x     = s1_r.x;
    s2_nxt.sx    = sx;
    s2_nxt.nsw   = s1_r.nsw;
    s2_nxt.nuw   = s1_r.nuw;
    s2_nxt.sum   = (s1_r.x + s1_r.y) & s1_r.m;
    s2_nxt.diff  = (s1_r.x - s1_r.y) & s1_r.m;
    s2_nxt.shl   = (s1_r.x << sh) & s1_r.m;
    s2_nxt.lshr  = s1_r.x >> sh;
    s2_nxt.ashr  = (s1_r.x >> sh) | (sx ? (s1_r.m & ~(s1_r.m >> sh)) : '0);
    s2_nxt.land  = s1_r.x & s1_r.y;
    s2_nxt.lor   = s1_r.x | s1_r.y;
    s2_nxt.lxor  = s1_r.x ^ s1_r.y;
    s2_nxt.cmpb  = (s1_r.cmask[0] && !sx && sy) ||
                   (s1_r.cmask[1] && sx && !sy) ||
                   (s1_r.cmask[2] && ugt && !(sx && !sy)) ||
                   (s1_r.cmask[3] && ult && !(!sx && sy)) ||
                   (s1_r.cmask[4] && eq);
    s2_nxt.sh_ok = (s1_r.y <= {57'd0, s1_r.w});
    s2_nxt.yzero = (s1_r.y == '0);
    s2_nxt.wok   = s1_r.wok;
    s2_nxt.pll   = s1_r.x[31:0]  * s1_r.y[31:0];
    s2_nxt.plh   = s1_r.x[31:0]  * s1_r.y[63:32];
    s2_nxt.phl   = s1_r.x[63:32] * s1_r.y[31:0];
    s2_nxt.phh   = s1_r.x[63:32] * s1_r.y[63:32];
    s2_nxt.negq  = sx ^ sy;
    s2_nxt.negr  = sx;
    if ((s1_r.op == OP_SDIV) || (s1_r.op == OP_SMOD)) begin
      s2_nxt.dvd = ua;
      s2_nxt.dvs = ub;
    end else begin
      s2_nxt.dvd = s1_r.x;
      s2_nxt.dvs = s1_r.y;
    end
  end

  // stage 3: wrap, shift-range and zero-divisor checks, result select, cross partial products
  always_comb begin
    logic bad;
    bad = 1'b0;
    s3_nxt.pre = '0;
    case (s2_r.op)
      OP_ADD: begin
        s3_nxt.pre = s2_r.sum;
        bad = s2_r.nuw && (s2_r.sum < s2_r.x);
      end
      OP_SUB: s3_nxt.pre = s2_r.diff;
      OP_MUL: s3_nxt.pre = '0;
      OP_SHL: begin
        s3_nxt.pre = s2_r.shl;
        bad = !s2_r.sh_ok ||
              (s2_r.nuw && (s2_r.shl < s2_r.x)) ||
              (s2_r.nsw && (s2_r.sx != |(s2_r.shl & s2_r.top)));
      end
      OP_SDIV, OP_UDIV, OP_SMOD, OP_UMOD: bad = s2_r.yzero;
      OP_ASHR: begin
        s3_nxt.pre = s2_r.ashr;
        bad = !s2_r.sh_ok;
      end
      OP_LSHR: begin
        s3_nxt.pre = s2_r.lshr;
        bad = !s2_r.sh_ok;
      end
      OP_AND: s3_nxt.pre = s2_r.land;
      OP_OR:  s3_nxt.pre = s2_r.lor;
      OP_XOR: s3_nxt.pre = s2_r.lxor;
      OP_CMP: s3_nxt.pre = {63'd0, s2_r.cmpb};
      default: bad = 1'b1;
    endcase
    s3_nxt.op   = s2_r.op;
    s3_nxt.m    = s2_r.m;
    s3_nxt.ok   = s2_r.wok && !bad && !((s2_r.op <= OP_UMOD) && s2_r.w_one);
    s3_nxt.nuw  = s2_r.nuw;
    s3_nxt.pll  = s2_r.pll;
    s3_nxt.phh  = s2_r.phh;
    s3_nxt.mid  = {1'b0, s2_r.plh} + {1'b0, s2_r.phl};
    s3_nxt.dvd  = s2_r.dvd;
    s3_nxt.dvs  = s2_r.dvs;
    s3_nxt.negq = s2_r.negq;
    s3_nxt.negr = s2_r.negr;
  end

  // stage 4: full product
  always_comb begin
    s4_nxt.op   = s3_r.op;
    s4_nxt.m    = s3_r.m;
    s4_nxt.ok   = s3_r.ok;
    s4_nxt.nuw  = s3_r.nuw;
    s4_nxt.pre  = s3_r.pre;
    s4_nxt.prod = {s3_r.phh, s3_r.pll} + {31'd0, s3_r.mid, 32'd0};
    s4_nxt.dvd  = s3_r.dvd;
    s4_nxt.dvs  = s3_r.dvs;
    s4_nxt.negq = s3_r.negq;
    s4_nxt.negr = s3_r.negr;
  end

  // stage 5: product overflow check, divider load
  always_comb begin
    logic over;
    over = (|s4_r.prod[127:64]) || (|(s4_r.prod[63:0] & ~s4_r.m));
    dv0_nxt.op   = s4_r.op;
    dv0_nxt.m    = s4_r.m;
    dv0_nxt.ok   = s4_r.ok && !((s4_r.op == OP_MUL) && s4_r.nuw && over);
    dv0_nxt.res  = (s4_r.op == OP_MUL) ? (s4_r.prod[63:0] & s4_r.m) : s4_r.pre;
    dv0_nxt.rem  = '0;
    dv0_nxt.num  = s4_r.dvd;
    dv0_nxt.den  = s4_r.dvs;
    dv0_nxt.negq = s4_r.negq;
    dv0_nxt.negr = s4_r.negr;
  end

  // output: quotient or remainder sign fix
  always_comb begin
    dv_t               d;
    logic [DATA_W-1:0] v;
    d = dv_r[DIV_STAGES];
    case (d.op)
      OP_SDIV: v = (d.negq ? (64'd0 - d.num) : d.num) & d.m;
      OP_SMOD: v = (d.negr ? (64'd0 - d.rem) : d.rem) & d.m;
      OP_UDIV: v = d.num;
      OP_UMOD: v = d.rem;
      default: v = d.res;
    endcase
    out_data_nxt.result    = d.ok ? v : '0;
    out_data_nxt.valid_res = d.ok;
  end

  // stage valid bits, divider chain included
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dv_v_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      dv_v_r[0]   <= s4_v_r;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
      out_valid_r <= dv_v_r[DIV_STAGES];
    end
  end

  // stage data, divider chain one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= s1_nxt;
      s2_r       <= s2_nxt;
      s3_r       <= s3_nxt;
      s4_r       <= s4_nxt;
      dv_r[0]    <= dv0_nxt;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        dv_r[k] <= div_step(dv_r[k-1]);
      end
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### hdl/cfia_checker.sv
// ----------------------------------------------------------------------------
// cfia_checker
// Port-level checks of the constant-fold integer alu, bound to the top level.
// ----------------------------------------------------------------------------
module cfia_checker
  import cfia_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input cfia_out_t out_data
);

  // a stalled result transfer holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input is held back only by a stalled full output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // undefined results read as zero
  a_bottom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.result == '0)
    else $error("undefined result is not zero");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind constant_fold_integer_alu_unit cfia_checker u_cfia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
